[src/btgr_pkg.sv]
// Shared types, constants and glyph ROM for the bitmap text glyph rasterizer.
package btgr_pkg;

  localparam int FIRST_CODE  = 32;
  localparam int GLYPH_COUNT = 64;
  localparam int GLYPH_ROWS  = 5;

  localparam int CODE_W   = 8;
  localparam int COORD_W  = 12;
  localparam int PEN_W    = 16;
  localparam int ADDR_W   = 20;
  localparam int DIM_W    = 11;
  localparam int GIDX_W   = 6;
  localparam int ROM_IDX_W = 9;
  localparam int ROM_DEPTH = GLYPH_COUNT * GLYPH_ROWS;

  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 40;

  localparam logic [PEN_W-1:0] PEN_MAX = 16'h7fff;

  // configuration register indexes
  localparam logic CFG_FB_COLS = 1'b0;
  localparam logic CFG_FB_ROWS = 1'b1;

  localparam logic [DIM_W-1:0] FB_COLS_RST = 11'd64;
  localparam logic [DIM_W-1:0] FB_ROWS_RST = 11'd32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  // glyph rows, bit 7 is the leftmost column
  localparam logic [7:0] GLYPH_ROM [ROM_DEPTH] = '{
    8'h00,8'h00,8'h00,8'h00,8'h00, 8'h80,8'h80,8'h80,8'h00,8'h80,
    8'ha0,8'ha0,8'h00,8'h00,8'h00, 8'ha0,8'he0,8'ha0,8'he0,8'ha0,
    8'he0,8'hc0,8'he0,8'h60,8'he0, 8'ha0,8'h20,8'h40,8'h80,8'ha0,
    8'hc0,8'h80,8'he0,8'h80,8'he0, 8'h80,8'h80,8'h00,8'h00,8'h00,
    8'h40,8'h80,8'h80,8'h80,8'h40, 8'h80,8'h40,8'h40,8'h40,8'h80,
    8'ha0,8'h40,8'ha0,8'h00,8'h00, 8'h00,8'h40,8'he0,8'h40,8'h00,
    8'h00,8'h00,8'h00,8'hc0,8'h40, 8'h00,8'h00,8'he0,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h80, 8'h20,8'h20,8'h40,8'h80,8'h80,
    8'h40,8'ha0,8'ha0,8'ha0,8'h40, 8'h40,8'hc0,8'h40,8'h40,8'he0,
    8'hc0,8'h20,8'h40,8'h80,8'he0, 8'he0,8'h20,8'h60,8'h20,8'he0,
    8'ha0,8'ha0,8'he0,8'h20,8'h20, 8'he0,8'h80,8'he0,8'h20,8'hc0,
    8'h60,8'h80,8'he0,8'ha0,8'he0, 8'he0,8'h20,8'h40,8'h80,8'h80,
    8'he0,8'ha0,8'he0,8'ha0,8'he0, 8'he0,8'ha0,8'he0,8'h20,8'hc0,
    8'h00,8'h80,8'h00,8'h80,8'h00, 8'h00,8'h40,8'h00,8'hc0,8'h40,
    8'h20,8'h40,8'h80,8'h40,8'h20, 8'h00,8'he0,8'h00,8'he0,8'h00,
    8'h80,8'h40,8'h20,8'h40,8'h80, 8'he0,8'h20,8'h60,8'h00,8'h40,
    8'he0,8'ha0,8'ha0,8'h80,8'he0, 8'he0,8'ha0,8'he0,8'ha0,8'ha0,
    8'hc0,8'ha0,8'hc0,8'ha0,8'hc0, 8'h60,8'h80,8'h80,8'h80,8'h60,
    8'hc0,8'ha0,8'ha0,8'ha0,8'hc0, 8'he0,8'h80,8'he0,8'h80,8'he0,
    8'he0,8'h80,8'he0,8'h80,8'h80, 8'h60,8'h80,8'ha0,8'ha0,8'h60,
    8'ha0,8'ha0,8'he0,8'ha0,8'ha0, 8'he0,8'h40,8'h40,8'h40,8'he0,
    8'h20,8'h20,8'h20,8'ha0,8'he0, 8'ha0,8'ha0,8'hc0,8'ha0,8'ha0,
    8'h80,8'h80,8'h80,8'h80,8'he0, 8'ha0,8'he0,8'ha0,8'ha0,8'ha0,
    8'he0,8'ha0,8'ha0,8'ha0,8'ha0, 8'he0,8'ha0,8'ha0,8'ha0,8'he0,
    8'he0,8'ha0,8'he0,8'h80,8'h80, 8'hc0,8'hc0,8'hc0,8'hc0,8'he0,
    8'hc0,8'ha0,8'hc0,8'ha0,8'ha0, 8'h60,8'h80,8'h40,8'h20,8'hc0,
    8'he0,8'h40,8'h40,8'h40,8'h40, 8'ha0,8'ha0,8'ha0,8'ha0,8'he0,
    8'ha0,8'ha0,8'ha0,8'ha0,8'hc0, 8'ha0,8'ha0,8'ha0,8'he0,8'ha0,
    8'ha0,8'ha0,8'h40,8'ha0,8'ha0, 8'ha0,8'ha0,8'he0,8'h40,8'h40,
    8'he0,8'h20,8'h40,8'h80,8'he0, 8'hc0,8'h80,8'h80,8'h80,8'hc0,
    8'h80,8'h80,8'h40,8'h20,8'h20, 8'hc0,8'h40,8'h40,8'h40,8'hc0,
    8'h40,8'ha0,8'ha0,8'h00,8'h00, 8'h00,8'h00,8'h00,8'h00,8'he0
  };

  localparam logic [1:0] GLYPH_WIDTH [GLYPH_COUNT] = '{
    2'd2,2'd1,2'd3,2'd3,2'd3,2'd3,2'd3,2'd1,2'd2,2'd2,2'd3,2'd3,2'd2,2'd3,2'd1,2'd3,
    2'd3,2'd3,2'd3,2'd3,2'd3,2'd3,2'd3,2'd3,2'd3,2'd3,2'd1,2'd2,2'd3,2'd3,2'd3,2'd3,
    2'd3,2'd3,2'd3,2'd3,2'd3,2'd3,2'd3,2'd3,2'd3,2'd3,2'd3,2'd3,2'd3,2'd3,2'd3,2'd3,
    2'd3,2'd3,2'd3,2'd3,2'd3,2'd3,2'd3,2'd3,2'd3,2'd3,2'd3,2'd2,2'd3,2'd2,2'd3,2'd3
  };

  // codes outside the printable range fall back to the blank glyph
  function automatic logic [GIDX_W-1:0] glyph_slot(input logic [CODE_W-1:0] code);
    logic [CODE_W-1:0] offs;
    offs = code - CODE_W'(FIRST_CODE);
    if (code < CODE_W'(FIRST_CODE) || offs >= CODE_W'(GLYPH_COUNT)) begin
      return '0;
    end
    return offs[GIDX_W-1:0];
  endfunction

endpackage

[src/bitmap_text_glyph_rasterizer.sv]
// Top level: 3x5 bitmap font rasterizer producing frame-buffer pixel addresses.
// Sequence: accept, a setup state for the row base multiply, then a scan state
// that walks the glyph cells (5 rows x width 1..3), then a flush state. One
// shared cell test/adder walks the glyph; output stalls hold the walk.
// Reset (synchronous): pen column 0, screen 64 x 32, no result pending.
module bitmap_text_glyph_rasterizer (
  input  logic                               clk,
  input  logic                               rst,
  // config write port
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [btgr_pkg::DIM_W-1:0]         cfg_data,
  // character stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [btgr_pkg::S_TDATA_W-1:0]     s_tdata,  // char_code, origin_x, origin_y
  input  logic                               s_tuser,  // first_of_string
  // pixel stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [btgr_pkg::M_TDATA_W-1:0]     m_tdata,  // pixel_address, pen_after, zero pad
  output logic                               m_tuser,  // write_enable
  output logic                               m_tlast   // last_of_char
);

  btgr_pkg::state_t state, state_next;

  logic [btgr_pkg::DIM_W-1:0]   fb_cols, fb_rows;
  logic [btgr_pkg::PEN_W-1:0]   pen_column;
  logic [btgr_pkg::GIDX_W-1:0]  gidx;
  logic [1:0]                   wid;
  logic [btgr_pkg::PEN_W-1:0]   x_reg;
  logic [btgr_pkg::COORD_W-1:0] y_reg;
  logic [2:0]                   py;
  logic [1:0]                   px;
  logic [btgr_pkg::ADDR_W-1:0]  row_base;
  logic                         pend_valid;
  logic [btgr_pkg::ADDR_W-1:0]  pend_addr;
  logic                         out_valid, out_we, out_last;
  logic [btgr_pkg::ADDR_W-1:0]  out_addr;
  logic [btgr_pkg::PEN_W-1:0]   out_pen;

  // input fields
  logic [btgr_pkg::CODE_W-1:0]  in_code;
  logic [btgr_pkg::COORD_W-1:0] in_ox, in_oy;
  logic                         accept;

  assign in_code = s_tdata[7:0];
  assign in_ox   = s_tdata[19:8];
  assign in_oy   = s_tdata[31:20];
  assign accept  = s_tvalid && s_tready;

  // glyph lookup and pen advance
  logic [btgr_pkg::GIDX_W-1:0] in_gidx;
  logic [1:0]                  in_wid;
  logic [btgr_pkg::PEN_W-1:0]  x_sel, pen_next;
  logic [btgr_pkg::PEN_W:0]    pen_sum;

  always_comb begin
    in_gidx = btgr_pkg::glyph_slot(in_code);
    in_wid  = btgr_pkg::GLYPH_WIDTH[in_gidx];
    x_sel   = s_tuser ? {{(btgr_pkg::PEN_W-btgr_pkg::COORD_W){in_ox[11]}}, in_ox}
                      : pen_column;
    pen_sum = {x_sel[btgr_pkg::PEN_W-1], x_sel} + {15'd0, in_wid} + 17'd1;
    // positive overflow only, the advance is small and positive
    if (pen_sum[16:15] == 2'b01) begin
      pen_next = btgr_pkg::PEN_MAX;
    end else begin
      pen_next = pen_sum[15:0];
    end
  end

  // row base: origin_y * fb_cols, modulo the address width
  logic signed [btgr_pkg::COORD_W-1:0]   y_s, sw_s;
  logic signed [2*btgr_pkg::COORD_W-1:0] prod;
  assign y_s  = $signed(y_reg);
  assign sw_s = $signed({1'b0, fb_cols});
  assign prod = y_s * sw_s;

  // cell test: clip to screen and check the glyph bit
  logic [btgr_pkg::ROM_IDX_W-1:0] rom_idx;
  logic [7:0]                     row_bits;
  logic [12:0]                    row13;
  logic [16:0]                    col17;
  logic                           row_ok, col_ok, bit_on, hit;
  logic [btgr_pkg::ADDR_W-1:0]    cell_addr;
  logic                           px_last, last_cell;

  always_comb begin
    rom_idx   = btgr_pkg::ROM_IDX_W'({3'd0, gidx} * 9'd5) + {6'd0, py};
    row_bits  = btgr_pkg::GLYPH_ROM[rom_idx];
    row13     = {y_reg[11], y_reg} + {10'd0, py};
    col17     = {x_reg[15], x_reg} + {15'd0, px};
    row_ok    = !row13[12] && (row13[11:0] < {1'b0, fb_rows});
    col_ok    = !col17[16] && (col17[15:0] < {5'd0, fb_cols});
    bit_on    = row_bits[3'd7 - {1'b0, px}];
    hit       = row_ok && col_ok && bit_on;
    cell_addr = row_base + {9'd0, col17[10:0]};
    px_last   = (px == wid - 2'd1);
    last_cell = px_last && (py == 3'(btgr_pkg::GLYPH_ROWS - 1));
  end

  // sequencer
  logic can_load, step_ok, load_out, load_last;

  assign can_load = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= btgr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    step_ok    = 1'b0;
    load_out   = 1'b0;
    load_last  = 1'b0;
    case (state)
      btgr_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = btgr_pkg::ST_SETUP;
      end
      btgr_pkg::ST_SETUP: begin
        state_next = btgr_pkg::ST_SCAN;
      end
      btgr_pkg::ST_SCAN: begin
        // a hit pushes the held pixel out, which needs the output register
        step_ok  = !(hit && pend_valid && !can_load);
        load_out = hit && pend_valid && can_load;
        if (step_ok && last_cell) state_next = btgr_pkg::ST_FLUSH;
      end
      btgr_pkg::ST_FLUSH: begin
        if (can_load) begin
          load_out   = 1'b1;
          load_last  = 1'b1;
          state_next = btgr_pkg::ST_IDLE;
        end
      end
      default: state_next = btgr_pkg::ST_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pen_column <= '0;
      fb_cols    <= btgr_pkg::FB_COLS_RST;
      fb_rows    <= btgr_pkg::FB_ROWS_RST;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == btgr_pkg::CFG_FB_COLS) fb_cols <= cfg_data;
        if (cfg_index == btgr_pkg::CFG_FB_ROWS) fb_rows <= cfg_data;
      end

      if (accept) begin
        gidx       <= in_gidx;
        wid        <= in_wid;
        x_reg      <= x_sel;
        y_reg      <= in_oy;
        pen_column <= pen_next;
        py         <= '0;
        px         <= '0;
        pend_valid <= 1'b0;
      end

      if (state == btgr_pkg::ST_SETUP) begin
        row_base <= prod[btgr_pkg::ADDR_W-1:0];
      end

      // walk one cell
      if (state == btgr_pkg::ST_SCAN && step_ok) begin
        if (hit) begin
          pend_valid <= 1'b1;
          pend_addr  <= cell_addr;
        end
        if (px_last) begin
          px       <= '0;
          py       <= py + 3'd1;
          row_base <= row_base + {9'd0, fb_cols};
        end else begin
          px <= px + 2'd1;
        end
      end

      if (state == btgr_pkg::ST_FLUSH && can_load) begin
        pend_valid <= 1'b0;
      end

      // output register
      if (load_out) begin
        out_valid <= 1'b1;
        out_we    <= load_last ? pend_valid : 1'b1;
        out_addr  <= pend_valid ? pend_addr : '0;
        out_last  <= load_last;
        out_pen   <= pen_column;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'd0, out_pen, out_addr};
  assign m_tuser  = out_we;
  assign m_tlast  = out_last;

  // checks
  a_no_pend_idle: assert property (@(posedge clk) disable iff (rst)
    state == btgr_pkg::ST_IDLE |-> !pend_valid)
    else $error("pixel held while idle");

  a_blank_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tlast && m_tdata[19:0] == '0))
    else $error("blank result not final or has an address");

  a_setup_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> state == btgr_pkg::ST_SETUP)
    else $error("accept did not start setup");

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    state == btgr_pkg::ST_SCAN |-> (py < 3'(btgr_pkg::GLYPH_ROWS) && px < wid))
    else $error("cell counter out of glyph");

  a_pen_saturates: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !s_tuser && pen_column == btgr_pkg::PEN_MAX)
      |=> pen_column == btgr_pkg::PEN_MAX)
    else $error("pen advance wrapped");

endmodule
